// File: rtl/core/sha1_hc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the SHA-1 hash core.
// No dependencies; imported by sha1_hc_round and sha1_hash_core.
package sha1_hc_pkg;

  localparam int unsigned RndW = 7;

  typedef logic [31:0]       word_t;
  typedef word_t [4:0]       hvec_t;   // element 0 is A / H0
  typedef logic [RndW-1:0]   rnd_t;

  localparam rnd_t RoundLast  = 7'd79;
  localparam rnd_t AddLast    = 7'd4;
  localparam rnd_t Stage1End  = 7'd20;
  localparam rnd_t Stage2End  = 7'd40;
  localparam rnd_t Stage3End  = 7'd60;

  localparam hvec_t InitChain = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

endpackage

// File: rtl/core/sha1_hc_round.sv
`timescale 1ns / 1ps
// One SHA-1 compression round: round function, constant select and the
// five-operand add. Depends on sha1_hc_pkg.
module sha1_hc_round (
  input  sha1_hc_pkg::hvec_t work_i,
  input  sha1_hc_pkg::word_t w_i,
  input  sha1_hc_pkg::rnd_t  rnd_i,
  output sha1_hc_pkg::hvec_t work_o
);
  import sha1_hc_pkg::*;

  word_t a, b, c, d, e, f, k, t;

  always_comb begin
    a = work_i[0];
    b = work_i[1];
    c = work_i[2];
    d = work_i[3];
    e = work_i[4];
    priority if (rnd_i < Stage1End) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd_i < Stage2End) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd_i < Stage3End) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w_i;
    work_o[0] = t;
    work_o[1] = a;
    work_o[2] = {b[1:0], b[31:2]};
    work_o[3] = c;
    work_o[4] = d;
  end

endmodule

// File: rtl/core/sha1_hash_core.sv
`timescale 1ns / 1ps
// SHA-1 hash core: byte buffer, schedule window, round sequencer and digest.
// Depends on sha1_hc_pkg and sha1_hc_round.
//
// Input channel: one transaction per byte (data_byte_i, carries_byte_i,
// last_i). A transaction with carries_byte_i low and last_i high ends a
// message without adding a byte, so the empty message can be hashed.
// Output channel: one transaction per message holding the five digest words,
// digest_word0_o being H0.
// Bytes that do not complete a 64-byte block are taken at one per cycle while in_stall_o is low.
// Completing a block starts a compression: the working variables load on the
// accepting edge, then 80 rounds through the single round unit and five
// steps of chain update through one adder, during all of which in_stall_o is
// high.
// Closing a message runs a padding step, one or two compressions (with a
// length step between two) and a load of the digest register; two
// compressions are needed when fewer than 9 bytes of space are left in the
// last block.
// The digest waits in an output register while out_stall_i is high; the next
// message can be taken meanwhile, and only its final digest load waits.
// Reset restores the initial chain value and clears the byte count and the
// output valid flag.
module sha1_hash_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                carries_byte_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sha1_hc_pkg::word_t  digest_word0_o,
  output sha1_hc_pkg::word_t  digest_word1_o,
  output sha1_hc_pkg::word_t  digest_word2_o,
  output sha1_hc_pkg::word_t  digest_word3_o,
  output sha1_hc_pkg::word_t  digest_word4_o
);
  import sha1_hc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LEN, S_ROUND, S_ADD, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_BLOCK, PH_EXTRA, PH_FINAL
  } phase_e;

  state_e        state_q, state_d;
  phase_e        phase_q, phase_d;
  logic          last_q;
  logic [60:0]   cnt_q;
  rnd_t          rnd_q;
  logic          out_valid_q;
  hvec_t         chain_q;
  hvec_t         work_q, work_next;
  hvec_t         digest_q;
  word_t         win_q [16];
  word_t         sched_new;
  logic [63:0]   bit_len;
  logic [5:0]    pos;
  logic [3:0]    word_idx;
  logic [1:0]    lane;
  logic          in_acc;
  logic          byte_acc;
  logic          out_free;

  assign pos      = cnt_q[5:0];
  assign word_idx = pos[5:2];
  assign lane     = pos[1:0];
  assign bit_len  = {cnt_q, 3'b000};
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign byte_acc = in_acc && carries_byte_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // Place a byte in its lane; the first byte of a word clears the rest.
  function automatic word_t put_byte(word_t cur, logic [1:0] ln, logic [7:0] b);
    word_t r;
    r = (ln == 2'd0) ? '0 : cur;
    for (int l = 0; l < 4; l++) begin
      if (ln == 2'(l)) r[8*(3-l) +: 8] = b;
    end
    return r;
  endfunction

  sha1_hc_round u_round (
    .work_i (work_q),
    .w_i    (win_q[0]),
    .rnd_i  (rnd_q),
    .work_o (work_next)
  );

  assign sched_new = {win_q[13][30:0] ^ win_q[8][30:0] ^ win_q[2][30:0] ^ win_q[0][30:0],
                      win_q[13][31] ^ win_q[8][31] ^ win_q[2][31] ^ win_q[0][31]};

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (carries_byte_i && (pos == 6'd63)) begin
            state_d = S_ROUND;
            phase_d = PH_BLOCK;
          end else if (last_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        state_d = S_ROUND;
        phase_d = (pos >= 6'd56) ? PH_EXTRA : PH_FINAL;
      end
      S_LEN: begin
        state_d = S_ROUND;
        phase_d = PH_FINAL;
      end
      S_ROUND: begin
        if (rnd_q == RoundLast) state_d = S_ADD;
      end
      S_ADD: begin
        if (rnd_q == AddLast) begin
          unique case (phase_q)
            PH_BLOCK: state_d = last_q ? S_PAD : S_IDLE;
            PH_EXTRA: state_d = S_LEN;
            PH_FINAL: state_d = S_DONE;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control, counters, chain value and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_BLOCK;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
      chain_q     <= InitChain;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (in_acc) last_q <= last_i;
      if (byte_acc) cnt_q <= cnt_q + 61'd1;
      if ((state_q == S_ROUND) || (state_q == S_ADD)) begin
        rnd_q <= (state_d == state_q) ? rnd_q + 7'd1 : '0;
      end
      if (state_q == S_ADD) begin
        // Rotate through the one adder; five steps restore the order.
        for (int i = 0; i < 4; i++) chain_q[i] <= chain_q[i+1];
        chain_q[4] <= chain_q[0] + work_q[0];
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
        chain_q     <= InitChain;
        cnt_q       <= '0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working variables and digest register.
  always_ff @(posedge clk_i) begin
    if ((state_q != S_ROUND) && (state_d == S_ROUND)) begin
      work_q <= chain_q;
    end else if (state_q == S_ROUND) begin
      work_q <= work_next;
    end else if (state_q == S_ADD) begin
      for (int i = 0; i < 4; i++) work_q[i] <= work_q[i+1];
      work_q[4] <= work_q[0];
    end
    if ((state_q == S_DONE) && out_free) digest_q <= chain_q;
  end

  // Message block and schedule window.
  always_ff @(posedge clk_i) begin
    if (state_q == S_ROUND) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= sched_new;
    end else if (byte_acc) begin
      win_q[word_idx] <= put_byte(win_q[word_idx], lane, data_byte_i);
    end else if (state_q == S_PAD) begin
      for (int i = 0; i < 16; i++) begin
        if (4'(i) > word_idx) begin
          if ((pos < 6'd56) && (i == 14)) win_q[i] <= bit_len[63:32];
          else if ((pos < 6'd56) && (i == 15)) win_q[i] <= bit_len[31:0];
          else win_q[i] <= '0;
        end
      end
      win_q[word_idx] <= put_byte(win_q[word_idx], lane, PadByte);
    end else if (state_q == S_LEN) begin
      for (int i = 0; i < 14; i++) win_q[i] <= '0;
      win_q[14] <= bit_len[63:32];
      win_q[15] <= bit_len[31:0];
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign digest_word0_o = digest_q[0];
  assign digest_word1_o = digest_q[1];
  assign digest_word2_o = digest_q[2];
  assign digest_word3_o = digest_q[3];
  assign digest_word4_o = digest_q[4];

`ifndef ASSERT_OFF
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> (rnd_q <= RoundLast))
    else $error("round index beyond last round");

  a_add_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |-> (rnd_q <= AddLast))
    else $error("chain update step out of range");

  a_digest_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("digest raised outside final step");

  a_msg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && out_free) |=> ((cnt_q == '0) && (state_q == S_IDLE)))
    else $error("message state not cleared after digest");
`endif

endmodule
